### rtl/core/dtc_pkg.sv
package dtc_pkg;

	localparam int MAX_ISOLATES_DEF = 1024;
	localparam int HEIGHT_BITS_DEF  = 32;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD     = 2'd0,
		REG_MERGE_ROWS    = 2'd1,
		REG_ISOLATE_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WALK_RD,
		ST_WALK_LEFT,
		ST_WALK_RIGHT,
		ST_NUM_RD,
		ST_NUM_WR,
		ST_QUERY_RD,
		ST_QUERY_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic walk_init;
		logic clear_step;
		logic walk_start;
		logic num_start;
		logic walk_read;
		logic claim_left;
		logic claim_right;
		logic walk_step;
		logic num_read;
		logic num_write;
		logic set_walk_done;
		logic query_read;
		logic result_valid;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic clear_last;
		logic rows_zero;
		logic row_last;
		logic isos_zero;
		logic iso_last;
	} dp_sts_t;

	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

### rtl/core/dtc_ram.sv
module dtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = dtc_pkg::addr_w(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/dtc_ctrl.sv
module dtc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             kind,
	input  dtc_pkg::dp_sts_t sts,
	output dtc_pkg::dp_cmd_t cmd,
	output logic             busy,
	output logic             done
);

	dtc_pkg::state_t state_q;
	dtc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dtc_pkg::ST_IDLE: begin
				if (start && kind == dtc_pkg::KIND_QUERY) begin
					state_d = sts.walk_done ? dtc_pkg::ST_QUERY_RD : dtc_pkg::ST_CLEAR;
				end
			end
			dtc_pkg::ST_CLEAR: begin
				if (sts.clear_last) begin
					if (!sts.rows_zero) begin
						state_d = dtc_pkg::ST_WALK_RD;
					end else if (sts.isos_zero) begin
						state_d = dtc_pkg::ST_QUERY_RD;
					end else begin
						state_d = dtc_pkg::ST_NUM_RD;
					end
				end
			end
			dtc_pkg::ST_WALK_RD:   state_d = dtc_pkg::ST_WALK_LEFT;
			dtc_pkg::ST_WALK_LEFT: state_d = dtc_pkg::ST_WALK_RIGHT;
			dtc_pkg::ST_WALK_RIGHT: begin
				if (!sts.row_last) begin
					state_d = dtc_pkg::ST_WALK_RD;
				end else if (sts.isos_zero) begin
					state_d = dtc_pkg::ST_QUERY_RD;
				end else begin
					state_d = dtc_pkg::ST_NUM_RD;
				end
			end
			dtc_pkg::ST_NUM_RD: state_d = dtc_pkg::ST_NUM_WR;
			dtc_pkg::ST_NUM_WR: begin
				state_d = sts.iso_last ? dtc_pkg::ST_QUERY_RD : dtc_pkg::ST_NUM_RD;
			end
			dtc_pkg::ST_QUERY_RD:  state_d = dtc_pkg::ST_QUERY_OUT;
			dtc_pkg::ST_QUERY_OUT: state_d = dtc_pkg::ST_IDLE;
			default:               state_d = dtc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			dtc_pkg::ST_IDLE: begin
				if (start) begin
					if (kind == dtc_pkg::KIND_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.capture   = 1'b1;
						cmd.walk_init = !sts.walk_done;
					end
				end
			end
			dtc_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					cmd.walk_start    = 1'b1;
					cmd.num_start     = 1'b1;
					cmd.set_walk_done = sts.rows_zero && sts.isos_zero;
				end
			end
			dtc_pkg::ST_WALK_RD:   cmd.walk_read  = 1'b1;
			dtc_pkg::ST_WALK_LEFT: cmd.claim_left = 1'b1;
			dtc_pkg::ST_WALK_RIGHT: begin
				cmd.claim_right   = 1'b1;
				cmd.walk_step     = 1'b1;
				cmd.set_walk_done = sts.row_last && sts.isos_zero;
			end
			dtc_pkg::ST_NUM_RD: cmd.num_read = 1'b1;
			dtc_pkg::ST_NUM_WR: begin
				cmd.num_write     = 1'b1;
				cmd.set_walk_done = sts.iso_last;
			end
			dtc_pkg::ST_QUERY_RD:  cmd.query_read   = 1'b1;
			dtc_pkg::ST_QUERY_OUT: cmd.result_valid = 1'b1;
			default:               cmd = '0;
		endcase
	end

	assign busy = (state_q != dtc_pkg::ST_IDLE);
	assign done = cmd.result_valid;

	a_query_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dtc_pkg::ST_QUERY_RD |-> sts.walk_done)
		else $error("Label read started before the walk finished.");

	a_no_walk_twice: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtc_pkg::ST_CLEAR || state_q == dtc_pkg::ST_WALK_RD ||
		 state_q == dtc_pkg::ST_WALK_LEFT || state_q == dtc_pkg::ST_WALK_RIGHT ||
		 state_q == dtc_pkg::ST_NUM_RD || state_q == dtc_pkg::ST_NUM_WR)
		|-> !sts.walk_done)
		else $error("Walk in progress while the labels are marked complete.");

	a_fast_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtc_pkg::ST_IDLE && start && kind == dtc_pkg::KIND_QUERY &&
		 sts.walk_done) |=> state_q == dtc_pkg::ST_QUERY_RD)
		else $error("Query after a finished walk did not go straight to the read.");

endmodule

### rtl/core/dtc_datapath.sv
module dtc_datapath #(
	parameter int MAX_ISOLATES = dtc_pkg::MAX_ISOLATES_DEF,
	parameter int HEIGHT_BITS  = dtc_pkg::HEIGHT_BITS_DEF,
	localparam int IDX_W   = $clog2(MAX_ISOLATES),
	localparam int CODE_W  = IDX_W + 1,
	localparam int LABEL_W = IDX_W + 1,
	localparam int CNT_W   = IDX_W + 1,
	localparam int CFG_W   = (HEIGHT_BITS > CNT_W) ? HEIGHT_BITS : CNT_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dtc_pkg::dp_cmd_t                   cmd,
	output dtc_pkg::dp_sts_t                   sts,
	input  logic                               cfg_we,
	input  logic [dtc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]                   cfg_wdata,
	input  logic signed [CODE_W-1:0]           left_child,
	input  logic signed [CODE_W-1:0]           right_child,
	input  logic signed [HEIGHT_BITS-1:0]      height,
	input  logic [IDX_W-1:0]                   isolate_index,
	output logic [LABEL_W-1:0]                 cluster_label
);

	localparam int ROW_DEPTH = MAX_ISOLATES - 1;
	localparam int ROW_AW    = dtc_pkg::addr_w(ROW_DEPTH);
	localparam int ISO_AW    = dtc_pkg::addr_w(MAX_ISOLATES);

	logic signed [HEIGHT_BITS-1:0] threshold_q;
	logic [IDX_W-1:0]              merge_rows_q;
	logic [CNT_W-1:0]              isolate_count_q;
	logic [IDX_W-1:0]              rows_loaded_q;
	logic                          walk_done_q;
	logic [ISO_AW-1:0]             clr_cnt_q;
	logic [IDX_W-1:0]              row_cnt_q;
	logic [CNT_W-1:0]              num_cnt_q;
	logic [LABEL_W-1:0]            single_q;
	logic [IDX_W-1:0]              idx_q;

	logic [IDX_W-1:0]    eff_rows;
	logic [CNT_W-1:0]    eff_isos;
	logic [IDX_W-1:0]    row_addr;
	logic                row_ok;
	logic                above;
	logic [IDX_W-1:0]    cur_row;
	logic [2*CODE_W-1:0] child_rd;
	logic                flag_rd;
	logic [LABEL_W-1:0]  owner_rd;
	logic [LABEL_W-1:0]  label_rd;
	logic [LABEL_W-1:0]  owner;
	logic [CODE_W-1:0]   claim_code;
	logic                claim;
	logic                is_iso;
	logic [CODE_W-1:0]   iso_idx;
	logic                iso_ok;
	logic                child_ok;
	logic [IDX_W-1:0]    child_row;
	logic                label_zero;

	logic                label_we;
	logic [ISO_AW-1:0]   label_waddr;
	logic [LABEL_W-1:0]  label_wdata;
	logic                label_re;
	logic [ISO_AW-1:0]   label_raddr;
	logic                owner_we;
	logic [ROW_AW-1:0]   owner_waddr;
	logic [LABEL_W-1:0]  owner_wdata;
	logic                flag_we;
	logic [ROW_AW-1:0]   flag_waddr;
	logic                flag_wdata;
	logic                child_we;

	assign eff_rows = (merge_rows_q > IDX_W'(ROW_DEPTH)) ? IDX_W'(ROW_DEPTH) : merge_rows_q;
	assign eff_isos = (isolate_count_q > CNT_W'(MAX_ISOLATES)) ? CNT_W'(MAX_ISOLATES)
		: isolate_count_q;

	assign row_addr = walk_done_q ? '0 : rows_loaded_q;
	assign row_ok   = row_addr < IDX_W'(ROW_DEPTH);
	assign above    = height > threshold_q;

	assign cur_row    = row_cnt_q - IDX_W'(1);
	assign owner      = (owner_rd != '0) ? owner_rd : LABEL_W'(row_cnt_q);
	assign claim_code = cmd.claim_right ? child_rd[CODE_W-1:0] : child_rd[2*CODE_W-1:CODE_W];
	assign claim      = (cmd.claim_left || cmd.claim_right) && flag_rd;
	assign is_iso     = claim_code[CODE_W-1];
	assign iso_idx    = ~claim_code;
	assign iso_ok     = is_iso && (iso_idx < eff_isos);
	assign child_ok   = !is_iso && (claim_code != '0) && (claim_code[IDX_W-1:0] <= eff_rows);
	assign child_row  = claim_code[IDX_W-1:0] - IDX_W'(1);
	assign label_zero = (label_rd == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q     <= '0;
			merge_rows_q    <= '0;
			isolate_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			case (dtc_pkg::cfg_reg_t'(cfg_index))
				dtc_pkg::REG_THRESHOLD:     threshold_q     <= cfg_wdata[HEIGHT_BITS-1:0];
				dtc_pkg::REG_MERGE_ROWS:    merge_rows_q    <= cfg_wdata[IDX_W-1:0];
				dtc_pkg::REG_ISOLATE_COUNT: isolate_count_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_loaded_q <= '0;
			walk_done_q   <= 1'b0;
			single_q      <= '0;
		end else begin
			if (cmd.load) begin
				walk_done_q <= 1'b0;
				if (row_ok) begin
					rows_loaded_q <= row_addr + IDX_W'(1);
				end
			end else if (cmd.set_walk_done) begin
				walk_done_q <= 1'b1;
			end
			if (cmd.num_start) begin
				single_q <= LABEL_W'(merge_rows_q) + LABEL_W'(1);
			end else if (cmd.num_write && label_zero) begin
				single_q <= single_q + LABEL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			row_cnt_q <= '0;
			num_cnt_q <= '0;
		end else begin
			if (cmd.walk_init) begin
				clr_cnt_q <= '0;
			end else if (cmd.clear_step) begin
				clr_cnt_q <= clr_cnt_q + ISO_AW'(1);
			end
			if (cmd.walk_start) begin
				row_cnt_q <= eff_rows;
			end else if (cmd.walk_step) begin
				row_cnt_q <= cur_row;
			end
			if (cmd.num_start) begin
				num_cnt_q <= '0;
			end else if (cmd.num_write) begin
				num_cnt_q <= num_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= isolate_index;
		end
	end

	always_comb begin
		label_we    = cmd.clear_step || (claim && iso_ok) || (cmd.num_write && label_zero);
		label_waddr = num_cnt_q[ISO_AW-1:0];
		label_wdata = single_q;
		if (cmd.clear_step) begin
			label_waddr = clr_cnt_q;
			label_wdata = '0;
		end else if (claim) begin
			label_waddr = iso_idx[ISO_AW-1:0];
			label_wdata = owner;
		end
		label_re    = cmd.query_read || cmd.num_read;
		label_raddr = cmd.query_read ? idx_q[ISO_AW-1:0] : num_cnt_q[ISO_AW-1:0];

		owner_we    = (cmd.clear_step && !sts.clear_last) || (claim && child_ok);
		owner_waddr = cmd.clear_step ? clr_cnt_q[ROW_AW-1:0] : child_row[ROW_AW-1:0];
		owner_wdata = cmd.clear_step ? '0 : owner;

		flag_we    = (cmd.load && row_ok) || (claim && child_ok);
		flag_waddr = cmd.load ? row_addr[ROW_AW-1:0] : child_row[ROW_AW-1:0];
		flag_wdata = cmd.load ? above : 1'b1;

		child_we = cmd.load && row_ok;
	end

	dtc_ram #(.WIDTH(2 * CODE_W), .DEPTH(ROW_DEPTH)) u_child_ram (
		.clk   (clk),
		.we    (child_we),
		.waddr (row_addr[ROW_AW-1:0]),
		.wdata ({left_child, right_child}),
		.re    (cmd.walk_read),
		.raddr (cur_row[ROW_AW-1:0]),
		.rdata (child_rd)
	);

	dtc_ram #(.WIDTH(1), .DEPTH(ROW_DEPTH)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.re    (cmd.walk_read),
		.raddr (cur_row[ROW_AW-1:0]),
		.rdata (flag_rd)
	);

	dtc_ram #(.WIDTH(LABEL_W), .DEPTH(ROW_DEPTH)) u_owner_ram (
		.clk   (clk),
		.we    (owner_we),
		.waddr (owner_waddr),
		.wdata (owner_wdata),
		.re    (cmd.walk_read),
		.raddr (cur_row[ROW_AW-1:0]),
		.rdata (owner_rd)
	);

	dtc_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_ISOLATES)) u_label_ram (
		.clk   (clk),
		.we    (label_we),
		.waddr (label_waddr),
		.wdata (label_wdata),
		.re    (label_re),
		.raddr (label_raddr),
		.rdata (label_rd)
	);

	assign cluster_label = ({1'b0, idx_q} < eff_isos) ? label_rd : '0;

	assign sts.walk_done  = walk_done_q;
	assign sts.clear_last = (clr_cnt_q == ISO_AW'(MAX_ISOLATES - 1));
	assign sts.rows_zero  = (eff_rows == '0);
	assign sts.row_last   = (row_cnt_q == IDX_W'(1));
	assign sts.isos_zero  = (eff_isos == '0);
	assign sts.iso_last   = ((num_cnt_q + CNT_W'(1)) == eff_isos);

	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_valid |-> walk_done_q)
		else $error("Cluster label given out before the walk finished.");

	a_walk_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_read |-> (row_cnt_q != '0 && row_cnt_q <= eff_rows))
		else $error("Walk read outside the loaded rows.");

endmodule

### rtl/core/dendrogram_threshold_cut_unit.sv
// Channel   Ports                                              Handshake
// input     kind, left_child, right_child, height,             start && !busy
//           isolate_index
// result    cluster_label                                      done, one cycle
// config    cfg_index, cfg_wdata                               cfg_we
//
// A load item is taken in the idle state; loads may follow back to back.
// When the labels are current, a query goes from idle to the label read, then to the result.
// The first query after loading runs the walk first: a clearing pass over
// the label and owner tables, a read, left claim and right claim per merge row
// through the row tables, and a read and a write per isolate for the numbering pass.
// Reset clears the controller and the registers other than the captured query index; the tables are not cleared.
// The receiver cannot stall; done is high for exactly one cycle per query.
module dendrogram_threshold_cut_unit #(
	parameter int MAX_ISOLATES = dtc_pkg::MAX_ISOLATES_DEF,
	parameter int HEIGHT_BITS  = dtc_pkg::HEIGHT_BITS_DEF,
	localparam int IDX_W   = $clog2(MAX_ISOLATES),
	localparam int CODE_W  = IDX_W + 1,
	localparam int LABEL_W = IDX_W + 1,
	localparam int CFG_W   = (HEIGHT_BITS > IDX_W + 1) ? HEIGHT_BITS : IDX_W + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic signed [CODE_W-1:0]      left_child,
	input  logic signed [CODE_W-1:0]      right_child,
	input  logic signed [HEIGHT_BITS-1:0] height,
	input  logic [IDX_W-1:0]              isolate_index,
	output logic                          done,
	output logic [LABEL_W-1:0]            cluster_label,
	input  logic                          cfg_we,
	input  logic [dtc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_wdata
);

	dtc_pkg::dp_cmd_t cmd;
	dtc_pkg::dp_sts_t sts;

	dtc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dtc_datapath #(
		.MAX_ISOLATES (MAX_ISOLATES),
		.HEIGHT_BITS  (HEIGHT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.left_child    (left_child),
		.right_child   (right_child),
		.height        (height),
		.isolate_index (isolate_index),
		.cluster_label (cluster_label)
	);

endmodule

### dv/dendrogram_threshold_cut_unit_test.sv
module dendrogram_threshold_cut_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	class tree_cut_scoreboard;
		bit [10:0] left_code [0:1022];
		bit [10:0] right_code [0:1022];
		bit above_cut [0:1022];
		bit [10:0] owner_of [0:1022];
		bit [10:0] iso_label [0:1023];
		bit signed [31:0] cut_height = 0;
		bit [9:0] row_limit = 0;
		bit [10:0] iso_limit = 1;
		int rows_in = 0;
		int rows_filled = 0;
		bit walked = 0;
		logic [10:0] labels_due [$];
		int errors = 0;

		function void write_reg(dtc_pkg::cfg_reg_t r, bit [31:0] v);
			case (r)
				dtc_pkg::REG_THRESHOLD: cut_height = v;
				dtc_pkg::REG_MERGE_ROWS: row_limit = v[9:0];
				dtc_pkg::REG_ISOLATE_COUNT: iso_limit = v[10:0];
				default: ;
			endcase
		endfunction

		function int isos_in_use();
			return (iso_limit > 1024) ? 1024 : int'(iso_limit);
		endfunction

		function void claim(bit [10:0] code, bit [10:0] owner, int rows, int isos);
			int iso;
			if (code[10]) begin
				iso = 2048 - int'(code);
				if (iso <= isos)
					iso_label[iso - 1] = owner;
			end else if (code != 0 && int'(code) - 1 < rows) begin
				above_cut[code - 1] = 1'b1;
				owner_of[code - 1] = owner;
			end
		endfunction

		// Top-down pass: a marked row hands its owner label to its whole subtree.
		function void cut_tree();
			int rows;
			int isos;
			bit [10:0] owner;
			bit [10:0] next_label;
			rows = row_limit;
			isos = isos_in_use();
			foreach (owner_of[i]) owner_of[i] = '0;
			foreach (iso_label[i]) iso_label[i] = '0;
			for (int r = rows - 1; r >= 0; r--) begin
				if (!above_cut[r])
					continue;
				owner = (owner_of[r] != 0) ? owner_of[r] : 11'(r + 1);
				owner_of[r] = owner;
				claim(left_code[r], owner, rows, isos);
				claim(right_code[r], owner, rows, isos);
			end
			next_label = 11'(int'(row_limit) + 1);
			for (int i = 0; i < isos; i++) begin
				if (iso_label[i] == 0) begin
					iso_label[i] = next_label;
					next_label++;
				end
			end
			walked = 1'b1;
		endfunction

		function void note_item(bit k, bit [10:0] lc, bit [10:0] rc, bit signed [31:0] h,
				bit [9:0] idx);
			logic [10:0] lab;
			if (k == dtc_pkg::KIND_LOAD) begin
				if (walked) begin
					walked = 1'b0;
					rows_in = 0;
				end
				if (rows_in < 1023) begin
					left_code[rows_in] = lc;
					right_code[rows_in] = rc;
					above_cut[rows_in] = (h > cut_height);
					rows_in++;
					if (rows_in > rows_filled)
						rows_filled = rows_in;
				end
			end else begin
				if (!walked)
					cut_tree();
				lab = (int'(idx) < isos_in_use()) ? iso_label[idx] : 11'd0;
				labels_due = {labels_due, lab};
			end
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void check_label(logic [10:0] got);
			logic [10:0] want;
			if (labels_due.size() == 0) begin
				report($sformatf("unexpected cluster_label %0d", got));
				return;
			end
			want = labels_due.pop_front();
			if (got !== want)
				report($sformatf("cluster_label mismatch: expected %0d, got %0d", want, got));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic kind = 1'b0;
	logic signed [10:0] left_child = '0;
	logic signed [10:0] right_child = '0;
	logic signed [31:0] height = '0;
	logic [9:0] isolate_index = '0;
	logic cfg_we = 1'b0;
	logic [dtc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	wire busy;
	wire done;
	wire [10:0] cluster_label;

	tree_cut_scoreboard sb = new();
	int burst_left = 0;
	int row_l [$];
	int row_r [$];
	longint row_h [$];

	dendrogram_threshold_cut_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.left_child(left_child),
		.right_child(right_child),
		.height(height),
		.isolate_index(isolate_index),
		.done(done),
		.cluster_label(cluster_label),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_label(cluster_label);
	end

	task automatic send_item(bit k, int lc, int rc, longint h, int idx);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 10);
		end
		start <= 1'b1;
		kind <= k;
		left_child <= lc[10:0];
		right_child <= rc[10:0];
		height <= h[31:0];
		isolate_index <= idx[9:0];
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(k, 11'(lc), 11'(rc), 32'(h), 10'(idx));
		burst_left--;
	endtask

	task automatic load_row(int lc, int rc, longint h);
		send_item(dtc_pkg::KIND_LOAD, lc, rc, h, $urandom_range(0, 1023));
	endtask

	task automatic query(int idx);
		send_item(dtc_pkg::KIND_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047),
			longint'($urandom), idx);
	endtask

	// Waits until every label has come back and the unit is idle again.
	task automatic settle();
		start <= 1'b0;
		burst_left = 0;
		while (sb.labels_due.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(dtc_pkg::cfg_reg_t r, longint v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v[31:0];
		@(posedge clk);
		sb.write_reg(r, v[31:0]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Well-formed dendrogram over n isolates with non-decreasing heights.
	function automatic void build_tree(int n);
		int pool [$];
		int i;
		int a;
		int b;
		longint h;
		row_l.delete();
		row_r.delete();
		row_h.delete();
		for (int k = 1; k <= n; k++)
			pool = {pool, -k};
		h = ($urandom_range(0, 7) == 0) ? -64'sd2147483648 : longint'(int'($urandom)) / 2;
		for (int r = 0; r < n - 1; r++) begin
			i = $urandom_range(0, pool.size() - 1);
			a = pool[i];
			pool.delete(i);
			i = $urandom_range(0, pool.size() - 1);
			b = pool[i];
			pool.delete(i);
			row_l = {row_l, a};
			row_r = {row_r, b};
			row_h = {row_h, h};
			pool = {pool, r + 1};
			h += $urandom_range(0, 32'h30000);
			if (h > 64'sd2147483647)
				h = 64'sd2147483647;
		end
	endfunction

	function automatic int pick_code(int span);
		if ($urandom_range(0, 1) == 0)
			return int'($urandom_range(0, 2047)) - 1024;
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic void build_noise(int nr);
		row_l.delete();
		row_r.delete();
		row_h.delete();
		for (int r = 0; r < nr; r++) begin
			row_l = {row_l, pick_code(nr + 3)};
			row_r = {row_r, pick_code(nr + 3)};
			row_h = {row_h, longint'(int'($urandom))};
		end
	endfunction

	function automatic longint choose_cut();
		longint h;
		if (row_h.size() == 0)
			return longint'(int'($urandom));
		h = row_h[$urandom_range(0, row_h.size() - 1)];
		case ($urandom_range(0, 9))
			0: return -64'sd2147483648;
			1: return 64'sd2147483647;
			2, 3: return longint'(int'($urandom));
			4, 5: return (h == -64'sd2147483648) ? h : h - 1;
			default: return h;
		endcase
	endfunction

	function automatic int pick_index();
		if ($urandom_range(0, 6) == 0)
			return $urandom_range(0, 1023);
		return $urandom_range(0, sb.isos_in_use() - 1);
	endfunction

	function automatic int pick_rows(int nr);
		int lim;
		lim = (nr > sb.rows_filled) ? nr : sb.rows_filled;
		if (lim > 1023)
			lim = 1023;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim) : nr;
	endfunction

	initial begin
		int n;
		int nr;
		int nq;
		int rand_items;
		bit mid_cut;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Query straight after reset uses the reset configuration.
		query(0);
		query(5);
		settle();

		// The threshold in force at load time decides each row's mark.
		write_reg(dtc_pkg::REG_THRESHOLD, -64'sd2147483648);
		write_reg(dtc_pkg::REG_MERGE_ROWS, 3);
		write_reg(dtc_pkg::REG_ISOLATE_COUNT, 4);
		load_row(-1, -2, -64'sd2147483648);
		settle();
		write_reg(dtc_pkg::REG_THRESHOLD, 32'h0001_0000);
		load_row(-3, -4, 32'h0001_0000);
		load_row(1, 2, 64'sd2147483647);
		query(0);
		query(3);
		query(1023);
		settle();

		// Writes after the walk leave the labels alone; the count is clamped.
		write_reg(dtc_pkg::REG_THRESHOLD, 64'sd2147483647);
		write_reg(dtc_pkg::REG_ISOLATE_COUNT, 2047);
		write_reg(dtc_pkg::REG_MERGE_ROWS, 1);
		query(3);
		query(1023);
		query(4);
		settle();

		// New tree with a zero code, an out-of-range isolate and row, and a self reference.
		write_reg(dtc_pkg::REG_THRESHOLD, -64'sd2147483648);
		write_reg(dtc_pkg::REG_MERGE_ROWS, 3);
		write_reg(dtc_pkg::REG_ISOLATE_COUNT, 6);
		load_row(0, -1024, 5);
		load_row(-6, 5, 7);
		load_row(-5, 3, 9);
		query(0);
		query(4);
		query(5);
		query(6);
		settle();

		// Full row store: one extra load is dropped.
		build_tree(1024);
		write_reg(dtc_pkg::REG_ISOLATE_COUNT, 2047);
		write_reg(dtc_pkg::REG_MERGE_ROWS, 1023);
		write_reg(dtc_pkg::REG_THRESHOLD, choose_cut());
		foreach (row_l[i])
			load_row(row_l[i], row_r[i], row_h[i]);
		load_row(-7, -8, 64'sd2147483647);
		query(0);
		query(1023);
		repeat (10) query(pick_index());
		settle();

		rand_items = 0;
		while (rand_items < 600) begin
			settle();
			if ($urandom_range(0, 3) == 0) begin
				nr = $urandom_range(1, 20);
				build_noise(nr);
				n = $urandom_range(1, nr + 4);
			end else begin
				case ($urandom_range(0, 19))
					0: n = $urandom_range(100, 300);
					1, 2, 3: n = $urandom_range(25, 99);
					default: n = $urandom_range(1, 24);
				endcase
				build_tree(n);
				nr = n - 1;
			end
			case ($urandom_range(0, 9))
				0: write_reg(dtc_pkg::REG_ISOLATE_COUNT, 2047);
				1: write_reg(dtc_pkg::REG_ISOLATE_COUNT, 1024);
				2, 3: write_reg(dtc_pkg::REG_ISOLATE_COUNT, $urandom_range(1, n + 2));
				default: write_reg(dtc_pkg::REG_ISOLATE_COUNT, n);
			endcase
			write_reg(dtc_pkg::REG_MERGE_ROWS, pick_rows(nr));
			write_reg(dtc_pkg::REG_THRESHOLD, choose_cut());
			mid_cut = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < nr; k++) begin
				if (mid_cut && k == nr / 2) begin
					settle();
					write_reg(dtc_pkg::REG_THRESHOLD, choose_cut());
				end
				load_row(row_l[k], row_r[k], row_h[k]);
				rand_items++;
			end
			nq = $urandom_range(1, 16);
			repeat (nq) query(pick_index());
			rand_items += nq;
			if ($urandom_range(0, 5) == 0) begin
				settle();
				case ($urandom_range(0, 2))
					0: write_reg(dtc_pkg::REG_THRESHOLD, longint'(int'($urandom)));
					1: write_reg(dtc_pkg::REG_MERGE_ROWS, pick_rows(0));
					default: write_reg(dtc_pkg::REG_ISOLATE_COUNT, $urandom_range(1, 1024));
				endcase
				nq = $urandom_range(1, 4);
				repeat (nq) query(pick_index());
				rand_items += nq;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.labels_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### dendrogram_threshold_cut_unit.f
rtl/core/dtc_pkg.sv
rtl/core/dtc_ram.sv
rtl/core/dtc_ctrl.sv
rtl/core/dtc_datapath.sv
rtl/core/dendrogram_threshold_cut_unit.sv
dv/dendrogram_threshold_cut_unit_test.sv
